### design/affine_warp_four_corner_sampler_top_macros.svh
// Assertion helpers shared by the sampler modules.
`ifndef AFFINE_WARP_FOUR_CORNER_SAMPLER_TOP_MACROS_SVH
`define AFFINE_WARP_FOUR_CORNER_SAMPLER_TOP_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define AWFC_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define AWFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/awfc_pkg.sv
package awfc_pkg;

  localparam int POS_W  = 12;
  localparam int COEF_W = 32;
  localparam int SIZE_W = 9;
  localparam int CH_W   = 8;
  localparam int CFG_W  = 32;
  localparam int Q_DEPTH = 8;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_WRITE,
    OP_SAMPLE,
    OP_OUTSIDE
  } op_t;

  typedef enum logic [2:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_COEF_XX    = 3'd2,
    REG_COEF_XY    = 3'd3,
    REG_COEF_YX    = 3'd4,
    REG_COEF_YY    = 3'd5,
    REG_OFFSET_X   = 3'd6,
    REG_OFFSET_Y   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [SIZE_W-1:0] src_width;
    logic [SIZE_W-1:0] src_height;
    logic [COEF_W-1:0] coef_xx;
    logic [COEF_W-1:0] coef_xy;
    logic [COEF_W-1:0] coef_yx;
    logic [COEF_W-1:0] coef_yy;
    logic [COEF_W-1:0] offset_x;
    logic [COEF_W-1:0] offset_y;
  } cfg_t;

endpackage

### design/awfc_front.sv
module awfc_front #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRAC_BITS  = 16,
  parameter int AW         = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_accept,
  input  logic                            in_mode,
  input  logic [awfc_pkg::POS_W-1:0]      in_pos_x,
  input  logic [awfc_pkg::POS_W-1:0]      in_pos_y,
  input  awfc_pkg::pixel_t                in_pix,
  input  awfc_pkg::cfg_t                  cfg,
  output logic                            push,
  output awfc_pkg::op_t                   push_op,
  output logic [3:0][AW-1:0]              push_addr,
  output awfc_pkg::pixel_t                push_pix
);

  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int YW   = $clog2(MAX_HEIGHT);
  localparam int PXW  = awfc_pkg::POS_W + 1;
  localparam int PW   = awfc_pkg::COEF_W + PXW;
  localparam int SUMW = PW + 2;
  localparam int FXW  = SUMW - FRAC_BITS;
  localparam int SZW  = ($clog2(MAX_WIDTH + 1) > awfc_pkg::SIZE_W) ?
                        $clog2(MAX_WIDTH + 1) : awfc_pkg::SIZE_W;
  localparam int SZH  = ($clog2(MAX_HEIGHT + 1) > awfc_pkg::SIZE_W) ?
                        $clog2(MAX_HEIGHT + 1) : awfc_pkg::SIZE_W;

  // stage 1: products
  logic                          v1_r;
  logic                          mode1_r;
  logic [awfc_pkg::POS_W-1:0]    px1_r, py1_r;
  awfc_pkg::pixel_t              pix1_r;
  logic signed [PW-1:0]          pxx_r, pxy_r, pyx_r, pyy_r;
  logic signed [PW-1:0]          pxx_nxt, pxy_nxt, pyx_nxt, pyy_nxt;

  // stage 2: floors
  logic                          v2_r;
  logic                          mode2_r;
  logic [awfc_pkg::POS_W-1:0]    px2_r, py2_r;
  awfc_pkg::pixel_t              pix2_r;
  logic [FXW-1:0]                fx2_r, fy2_r;
  logic signed [SUMW-1:0]        sx_nxt, sy_nxt;

  // stage 3: classify and address
  logic [SZW-1:0]                eff_w;
  logic [SZH-1:0]                eff_h;
  logic                          in_image;
  logic                          wr_ok;
  logic [XW-1:0]                 fxc, wm1, xl, xr;
  logic [YW-1:0]                 fyc, hm1, yu, yd;
  logic [AW-1:0]                 row_u, row_d, row_w;
  logic                          push_r;
  awfc_pkg::op_t                 op_r, op_nxt;
  logic [3:0][AW-1:0]            addr_r, addr_nxt;
  awfc_pkg::pixel_t              pix_r;

  assign pxx_nxt = $signed(cfg.coef_xx) * $signed({1'b0, in_pos_x});
  assign pxy_nxt = $signed(cfg.coef_xy) * $signed({1'b0, in_pos_y});
  assign pyx_nxt = $signed(cfg.coef_yx) * $signed({1'b0, in_pos_x});
  assign pyy_nxt = $signed(cfg.coef_yy) * $signed({1'b0, in_pos_y});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_accept;
    end
    mode1_r <= in_mode;
    px1_r   <= in_pos_x;
    py1_r   <= in_pos_y;
    pix1_r  <= in_pix;
    pxx_r   <= pxx_nxt;
    pxy_r   <= pxy_nxt;
    pyx_r   <= pyx_nxt;
    pyy_r   <= pyy_nxt;
  end

  assign sx_nxt = SUMW'(pxx_r) + SUMW'(pxy_r) + SUMW'($signed(cfg.offset_x));
  assign sy_nxt = SUMW'(pyx_r) + SUMW'(pyy_r) + SUMW'($signed(cfg.offset_y));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    mode2_r <= mode1_r;
    px2_r   <= px1_r;
    py2_r   <= py1_r;
    pix2_r  <= pix1_r;
    // arithmetic shift of the two's complement sum is the floor
    fx2_r   <= sx_nxt[SUMW-1:FRAC_BITS];
    fy2_r   <= sy_nxt[SUMW-1:FRAC_BITS];
  end

  always_comb begin
    if (cfg.src_width == '0) begin
      eff_w = SZW'(1);
    end else if (SZW'(cfg.src_width) > SZW'(MAX_WIDTH)) begin
      eff_w = SZW'(MAX_WIDTH);
    end else begin
      eff_w = SZW'(cfg.src_width);
    end
    if (cfg.src_height == '0) begin
      eff_h = SZH'(1);
    end else if (SZH'(cfg.src_height) > SZH'(MAX_HEIGHT)) begin
      eff_h = SZH'(MAX_HEIGHT);
    end else begin
      eff_h = SZH'(cfg.src_height);
    end
  end

  always_comb begin
    in_image = !fx2_r[FXW-1] && (fx2_r < FXW'(eff_w)) &&
               !fy2_r[FXW-1] && (fy2_r < FXW'(eff_h));
    fxc = fx2_r[XW-1:0];
    fyc = fy2_r[YW-1:0];
    wm1 = XW'(eff_w - SZW'(1));
    hm1 = YW'(eff_h - SZH'(1));
    // diagonal neighbors, held at the image border
    xl  = (fxc == '0) ? fxc : fxc - XW'(1);
    xr  = (fxc == wm1) ? fxc : fxc + XW'(1);
    yu  = (fyc == '0) ? fyc : fyc - YW'(1);
    yd  = (fyc == hm1) ? fyc : fyc + YW'(1);
    row_u = AW'(yu) * AW'(MAX_WIDTH);
    row_d = AW'(yd) * AW'(MAX_WIDTH);
    row_w = AW'(py2_r[YW-1:0]) * AW'(MAX_WIDTH);
    wr_ok = ({1'b0, px2_r} < PXW'(MAX_WIDTH)) && ({1'b0, py2_r} < PXW'(MAX_HEIGHT));
    addr_nxt = '0;
    if (!mode2_r) begin
      op_nxt      = wr_ok ? awfc_pkg::OP_WRITE : awfc_pkg::OP_NOP;
      addr_nxt[0] = row_w + AW'(px2_r[XW-1:0]);
    end else if (in_image) begin
      op_nxt      = awfc_pkg::OP_SAMPLE;
      addr_nxt[0] = row_u + AW'(xl);
      addr_nxt[1] = row_u + AW'(xr);
      addr_nxt[2] = row_d + AW'(xl);
      addr_nxt[3] = row_d + AW'(xr);
    end else begin
      op_nxt      = awfc_pkg::OP_OUTSIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      push_r <= 1'b0;
    end else begin
      push_r <= v2_r;
    end
    op_r   <= op_nxt;
    addr_r <= addr_nxt;
    pix_r  <= pix2_r;
  end

  assign push      = push_r;
  assign push_op   = op_r;
  assign push_addr = addr_r;
  assign push_pix  = pix_r;

endmodule

### design/awfc_fifo.sv
`include "affine_warp_four_corner_sampler_top_macros.svh"

module awfc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           din,
  input  logic                       pop,
  output logic [WIDTH-1:0]           dout,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTRW = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTRW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTRW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             full;

  assign empty = (count_r == '0);
  assign full  = (count_r == CW'(DEPTH));
  assign dout  = mem_r[rd_ptr_r];
  assign count = count_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_r + PTRW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_r + PTRW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  `AWFC_ASSERT_ALWAYS(a_no_pop_empty, clk, rst_n, !(pop && empty), "pop from empty queue")
  `AWFC_ASSERT_ALWAYS(a_no_push_full, clk, rst_n, !(push && full && !pop), "push into full queue")

endmodule

### design/awfc_back.sv
`include "affine_warp_four_corner_sampler_top_macros.svh"

module awfc_back #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int AW         = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  awfc_pkg::op_t      head_op,
  input  logic [3:0][AW-1:0] head_addr,
  input  awfc_pkg::pixel_t   head_pix,
  output logic               pop,
  output logic               out_valid,
  output awfc_pkg::pixel_t   out_pix,
  output logic               out_inside
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

  function automatic awfc_pkg::pixel_t avg2(awfc_pkg::pixel_t a, awfc_pkg::pixel_t b);
    logic [awfc_pkg::CH_W:0] sr, sg, sb;
    awfc_pkg::pixel_t        res;
    sr = {1'b0, a.red}   + {1'b0, b.red};
    sg = {1'b0, a.green} + {1'b0, b.green};
    sb = {1'b0, a.blue}  + {1'b0, b.blue};
    res.red   = sr[awfc_pkg::CH_W:1];
    res.green = sg[awfc_pkg::CH_W:1];
    res.blue  = sb[awfc_pkg::CH_W:1];
    return res;
  endfunction

  awfc_pkg::pixel_t   mem [DEPTH];

  logic               cur_valid_r;
  awfc_pkg::op_t      cur_op_r;
  logic [3:0][AW-1:0] cur_addr_r;
  awfc_pkg::pixel_t   cur_pix_r;
  logic [1:0]         step_r;
  logic               done;
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_addr;
  awfc_pkg::pixel_t   rdata_r;

  logic               tag_valid_r;
  logic [1:0]         tag_step_r;
  logic               tag_out_r;

  awfc_pkg::pixel_t   a_r, ab_r, c_r;
  logic               out_valid_r, out_valid_nxt;
  awfc_pkg::pixel_t   out_pix_r, out_pix_nxt;
  logic               out_inside_r, out_inside_nxt;

  assign done = cur_valid_r && ((cur_op_r != awfc_pkg::OP_SAMPLE) || (step_r == 2'd3));
  assign pop  = head_valid && (!cur_valid_r || done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      step_r      <= '0;
    end else if (pop) begin
      cur_valid_r <= 1'b1;
      step_r      <= '0;
    end else if (done) begin
      cur_valid_r <= 1'b0;
    end else if (cur_valid_r) begin
      step_r      <= step_r + 2'd1;
    end
    if (pop) begin
      cur_op_r   <= head_op;
      cur_addr_r <= head_addr;
      cur_pix_r  <= head_pix;
    end
  end

  // single port frame store: one write or one read a cycle
  assign mem_we   = cur_valid_r && (cur_op_r == awfc_pkg::OP_WRITE);
  assign mem_re   = cur_valid_r && (cur_op_r == awfc_pkg::OP_SAMPLE);
  assign mem_addr = mem_we ? cur_addr_r[0] : cur_addr_r[step_r];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= cur_pix_r;
    end else if (mem_re) begin
      rdata_r <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_valid_r <= 1'b0;
    end else begin
      tag_valid_r <= mem_re || (cur_valid_r && (cur_op_r == awfc_pkg::OP_OUTSIDE));
    end
    tag_step_r <= step_r;
    tag_out_r  <= (cur_op_r == awfc_pkg::OP_OUTSIDE);
  end

  always_comb begin
    out_valid_nxt  = 1'b0;
    out_pix_nxt    = out_pix_r;
    out_inside_nxt = out_inside_r;
    if (tag_valid_r && tag_out_r) begin
      out_valid_nxt  = 1'b1;
      out_pix_nxt    = '0;
      out_inside_nxt = 1'b0;
    end else if (tag_valid_r && (tag_step_r == 2'd3)) begin
      out_valid_nxt  = 1'b1;
      out_pix_nxt    = avg2(ab_r, avg2(c_r, rdata_r));
      out_inside_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (tag_valid_r && !tag_out_r) begin
      unique case (tag_step_r)
        2'd0: a_r  <= rdata_r;
        2'd1: ab_r <= avg2(a_r, rdata_r);
        2'd2: c_r  <= rdata_r;
        2'd3: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_pix_r    <= out_pix_nxt;
    out_inside_r <= out_inside_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_pix    = out_pix_r;
  assign out_inside = out_inside_r;

  `AWFC_ASSERT_NEXT(a_last_read_gives_result, clk, rst_n, tag_valid_r && !tag_out_r && (tag_step_r == 2'd3), out_valid_r && out_inside_r, "fourth read gave no result")

endmodule

### design/affine_warp_four_corner_sampler_top.sv
// Channel  Ports                                         Handshake
// -------  --------------------------------------------  ---------------------------------
// input    in_mode in_pos_x in_pos_y in_red/green/blue   transfer when start && !busy
// result   out_red out_green out_blue out_inside_res     one-cycle strobe out_valid
// config   cfg_index cfg_wdata                           write when cfg_we, no wait
//
// A store item (mode 0) occupies the frame store for a single write; a sample item
// (mode 1) makes four reads, one per neighbor, of the single-port frame store.
// Results keep input order.
// Reset is synchronous and active low; it clears control and loads register defaults.
// busy rises while Q_DEPTH items are accepted but not yet taken up by the store side.
// The result side has no stall: each result is valid for exactly one cycle.
`include "affine_warp_four_corner_sampler_top_macros.svh"

module affine_warp_four_corner_sampler_top #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_mode,
  input  logic [awfc_pkg::POS_W-1:0]    in_pos_x,
  input  logic [awfc_pkg::POS_W-1:0]    in_pos_y,
  input  logic [awfc_pkg::CH_W-1:0]     in_red,
  input  logic [awfc_pkg::CH_W-1:0]     in_green,
  input  logic [awfc_pkg::CH_W-1:0]     in_blue,
  output logic                          out_valid,
  output logic [awfc_pkg::CH_W-1:0]     out_red,
  output logic [awfc_pkg::CH_W-1:0]     out_green,
  output logic [awfc_pkg::CH_W-1:0]     out_blue,
  output logic                          out_inside_res,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [awfc_pkg::CFG_W-1:0]    cfg_wdata
);

  localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int OPW = $bits(awfc_pkg::op_t);
  localparam int PIXW = $bits(awfc_pkg::pixel_t);
  localparam int EW = OPW + 4 * AW + PIXW;
  localparam int RW = $clog2(awfc_pkg::Q_DEPTH + 1);

  awfc_pkg::cfg_t     cfg_r, cfg_nxt;
  logic [RW-1:0]      resv_r, resv_nxt;
  logic               accept;

  awfc_pkg::pixel_t   in_pix;
  logic               push;
  awfc_pkg::op_t      push_op;
  logic [3:0][AW-1:0] push_addr;
  awfc_pkg::pixel_t   push_pix;

  logic [EW-1:0]      q_din, q_dout;
  logic               q_pop, q_empty;
  logic [RW-1:0]      q_count;

  awfc_pkg::op_t      head_op;
  logic [3:0][AW-1:0] head_addr;
  awfc_pkg::pixel_t   head_pix;
  awfc_pkg::pixel_t   res_pix;

  // configuration registers; writes must only arrive while the block is idle, which the block does not enforce
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (awfc_pkg::reg_idx_t'(cfg_index))
        awfc_pkg::REG_SRC_WIDTH:  cfg_nxt.src_width  = cfg_wdata[awfc_pkg::SIZE_W-1:0];
        awfc_pkg::REG_SRC_HEIGHT: cfg_nxt.src_height = cfg_wdata[awfc_pkg::SIZE_W-1:0];
        awfc_pkg::REG_COEF_XX:    cfg_nxt.coef_xx    = cfg_wdata;
        awfc_pkg::REG_COEF_XY:    cfg_nxt.coef_xy    = cfg_wdata;
        awfc_pkg::REG_COEF_YX:    cfg_nxt.coef_yx    = cfg_wdata;
        awfc_pkg::REG_COEF_YY:    cfg_nxt.coef_yy    = cfg_wdata;
        awfc_pkg::REG_OFFSET_X:   cfg_nxt.offset_x   = cfg_wdata;
        awfc_pkg::REG_OFFSET_Y:   cfg_nxt.offset_y   = cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_width  <= awfc_pkg::SIZE_W'(256);
      cfg_r.src_height <= awfc_pkg::SIZE_W'(256);
      cfg_r.coef_xx    <= awfc_pkg::COEF_W'(1) << FRAC_BITS;
      cfg_r.coef_xy    <= '0;
      cfg_r.coef_yx    <= '0;
      cfg_r.coef_yy    <= awfc_pkg::COEF_W'(1) << FRAC_BITS;
      cfg_r.offset_x   <= '0;
      cfg_r.offset_y   <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Count items accepted but not yet popped by the store side. The front
  // pipeline never stalls, so holding this at or below the queue depth keeps the
  // queue from overflowing.
  assign busy   = (resv_r >= RW'(awfc_pkg::Q_DEPTH));
  assign accept = start && !busy;

  always_comb begin
    resv_nxt = resv_r;
    if (accept && !q_pop) begin
      resv_nxt = resv_r + RW'(1);
    end else if (q_pop && !accept) begin
      resv_nxt = resv_r - RW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resv_r <= '0;
    end else begin
      resv_r <= resv_nxt;
    end
  end

  assign in_pix.red   = in_red;
  assign in_pix.green = in_green;
  assign in_pix.blue  = in_blue;

  // front: map, floor, classify and form the neighbor or store addresses
  awfc_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS),
    .AW         (AW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (accept),
    .in_mode   (in_mode),
    .in_pos_x  (in_pos_x),
    .in_pos_y  (in_pos_y),
    .in_pix    (in_pix),
    .cfg       (cfg_r),
    .push      (push),
    .push_op   (push_op),
    .push_addr (push_addr),
    .push_pix  (push_pix)
  );

  assign q_din = {push_op, push_addr, push_pix};

  awfc_fifo #(
    .WIDTH (EW),
    .DEPTH (awfc_pkg::Q_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty),
    .count (q_count)
  );

  assign head_op   = awfc_pkg::op_t'(q_dout[EW-1 -: OPW]);
  assign head_addr = q_dout[PIXW +: 4 * AW];
  assign head_pix  = q_dout[PIXW-1:0];

  // back: frame store accesses and averaging
  awfc_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .AW         (AW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (!q_empty),
    .head_op    (head_op),
    .head_addr  (head_addr),
    .head_pix   (head_pix),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_pix    (res_pix),
    .out_inside (out_inside_res)
  );

  assign out_red   = res_pix.red;
  assign out_green = res_pix.green;
  assign out_blue  = res_pix.blue;

  `AWFC_ASSERT_ALWAYS(a_resv_bound, clk, rst_n, resv_r <= RW'(awfc_pkg::Q_DEPTH), "reservation count above queue depth")
  `AWFC_ASSERT_ALWAYS(a_queue_covered, clk, rst_n, q_count <= resv_r, "queue holds unreserved entries")
  `AWFC_ASSERT_NEXT(a_accept_counts, clk, rst_n, accept && !q_pop, resv_r == $past(resv_r) + RW'(1), "accepted transfer not counted")

endmodule

### test/affine_warp_four_corner_sampler_top_tb.sv
`timescale 1ns / 1ps

module affine_warp_four_corner_sampler_top_tb;

  localparam int POS_W  = awfc_pkg::POS_W;
  localparam int CH_W   = awfc_pkg::CH_W;
  localparam int SIZE_W = awfc_pkg::SIZE_W;
  localparam int COEF_W = awfc_pkg::COEF_W;
  localparam int CFG_W  = awfc_pkg::CFG_W;

  typedef awfc_pkg::pixel_t   pixel_t;
  typedef awfc_pkg::cfg_t     cfg_t;
  typedef awfc_pkg::reg_idx_t reg_idx_t;

  localparam int MAX_WIDTH     = 256;
  localparam int MAX_HEIGHT    = 256;
  localparam int FRAC_BITS     = 16;
  localparam int ONE_Q16       = 1 << FRAC_BITS;
  localparam int RANDOM_ITEMS  = 1700;
  // Up to Q_DEPTH stores may still sit in the input queue when the last sample comes out.
  localparam int SETTLE_CYCLES = 32;
  localparam int MAX_GAP       = 7;
  localparam int RUN_LIMIT_NS  = 12_000_000;

  localparam logic MODE_STORE  = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  // One destination pixel as it should leave the block.
  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            in_src;
  } warped_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_mode;
  logic [POS_W-1:0]  in_pos_x;
  logic [POS_W-1:0]  in_pos_y;
  logic [CH_W-1:0]   in_red;
  logic [CH_W-1:0]   in_green;
  logic [CH_W-1:0]   in_blue;
  logic              out_valid;
  logic [CH_W-1:0]   out_red;
  logic [CH_W-1:0]   out_green;
  logic [CH_W-1:0]   out_blue;
  logic              out_inside_res;
  logic              cfg_we;
  logic [2:0]        cfg_index;
  logic [CFG_W-1:0]  cfg_wdata;

  affine_warp_four_corner_sampler_top #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_mode       (in_mode),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .out_valid     (out_valid),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_inside_res(out_inside_res),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  // Shadow of the register file and of the frame store. frame_written marks
  // entries that hold a defined pixel; samples never touch any other entry.
  cfg_t    warp_cfg;
  pixel_t  frame_shadow [MAX_WIDTH*MAX_HEIGHT];
  bit      frame_written [MAX_WIDTH*MAX_HEIGHT];
  warped_t pending_pixels [$];
  warped_t head_pixel;

  int  mismatch_count;
  int  transfers;
  int  useful_items;
  int  samples_inside;
  int  samples_outside;
  int  warp_settings;
  bit  no_idle;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Size codes of 0 act as 1, codes past the frame act as the frame size.
  function automatic int eff_size(logic [SIZE_W-1:0] code, int max_size);
    if (code == 0) return 1;
    if (code > max_size) return max_size;
    return code;
  endfunction

  // Exact Q16.16 affine sum; an arithmetic shift gives the floor for both signs.
  function automatic longint floor_coord(logic [COEF_W-1:0] c_x, logic [COEF_W-1:0] c_y,
                                         logic [COEF_W-1:0] offs,
                                         logic [POS_W-1:0] x, logic [POS_W-1:0] y);
    longint s;
    s = longint'($signed(c_x)) * longint'(x) + longint'($signed(c_y)) * longint'(y)
        + longint'($signed(offs));
    return s >>> FRAC_BITS;
  endfunction

  function automatic int clamp_to(longint v, int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  // Map a destination point; on a hit return the clamped diagonal neighbors.
  function automatic bit map_neighbors(logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                       output int xl, output int xr,
                                       output int yu, output int yd);
    int     w;
    int     h;
    longint fx;
    longint fy;
    w  = eff_size(warp_cfg.src_width, MAX_WIDTH);
    h  = eff_size(warp_cfg.src_height, MAX_HEIGHT);
    fx = floor_coord(warp_cfg.coef_xx, warp_cfg.coef_xy, warp_cfg.offset_x, x, y);
    fy = floor_coord(warp_cfg.coef_yx, warp_cfg.coef_yy, warp_cfg.offset_y, x, y);
    xl = 0;
    xr = 0;
    yu = 0;
    yd = 0;
    if (fx < 0 || fx >= w || fy < 0 || fy >= h) return 1'b0;
    xl = clamp_to(fx - 1, w - 1);
    xr = clamp_to(fx + 1, w - 1);
    yu = clamp_to(fy - 1, h - 1);
    yd = clamp_to(fy + 1, h - 1);
    return 1'b1;
  endfunction

  // Average the top pair and the bottom pair, then the two halves.
  function automatic logic [CH_W-1:0] average_corners(logic [CH_W-1:0] a, logic [CH_W-1:0] b,
                                                      logic [CH_W-1:0] c, logic [CH_W-1:0] d);
    int top;
    int bottom;
    top    = (int'(a) + int'(b)) >> 1;
    bottom = (int'(c) + int'(d)) >> 1;
    return CH_W'((top + bottom) >> 1);
  endfunction

  function automatic warped_t warp_pixel(logic [POS_W-1:0] x, logic [POS_W-1:0] y);
    warped_t r;
    int      xl;
    int      xr;
    int      yu;
    int      yd;
    pixel_t  a;
    pixel_t  b;
    pixel_t  c;
    pixel_t  d;
    r = '0;
    // Outside points come out black with inside_res low.
    if (!map_neighbors(x, y, xl, xr, yu, yd)) return r;
    a = frame_shadow[yu*MAX_WIDTH + xl];
    b = frame_shadow[yu*MAX_WIDTH + xr];
    c = frame_shadow[yd*MAX_WIDTH + xl];
    d = frame_shadow[yd*MAX_WIDTH + xr];
    r.red    = average_corners(a.red, b.red, c.red, d.red);
    r.green  = average_corners(a.green, b.green, c.green, d.green);
    r.blue   = average_corners(a.blue, b.blue, c.blue, d.blue);
    r.in_src = 1'b1;
    return r;
  endfunction

  // Advance the shadow by one accepted transfer.
  function automatic void take_transfer(logic mode, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                        pixel_t px);
    warped_t r;
    transfers++;
    if (mode == MODE_STORE) begin
      // Stores past the frame are dropped by the block.
      if (x < MAX_WIDTH && y < MAX_HEIGHT) begin
        frame_shadow[y*MAX_WIDTH + x]  = px;
        frame_written[y*MAX_WIDTH + x] = 1'b1;
        useful_items++;
      end
    end else begin
      r = warp_pixel(x, y);
      if (r.in_src) samples_inside++;
      else samples_outside++;
      pending_pixels.push_back(r);
      useful_items++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Random helpers
  // ---------------------------------------------------------------------------

  function automatic pixel_t random_pixel();
    logic [3*CH_W-1:0] v;
    v = (3*CH_W)'($urandom);
    return v;
  endfunction

  // Mostly small frames; now and then the full frame or any size code at all.
  function automatic logic [SIZE_W-1:0] random_size();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return SIZE_W'($urandom_range(0, (1 << SIZE_W) - 1));
    if (pick == 1) return SIZE_W'(MAX_WIDTH);
    return SIZE_W'($urandom_range(1, 24));
  endfunction

  // Scale factor between a quarter and two, either sign.
  function automatic logic [COEF_W-1:0] random_scale();
    int mag;
    mag = $urandom_range(ONE_Q16 / 4, 2 * ONE_Q16);
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Present one item and hold it until the block takes the transfer.
  task automatic send_item(logic mode, logic [POS_W-1:0] x, logic [POS_W-1:0] y, pixel_t px);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start    <= 1'b1;
    in_mode  <= mode;
    in_pos_x <= x;
    in_pos_y <= y;
    in_red   <= px.red;
    in_green <= px.green;
    in_blue  <= px.blue;
    do @(posedge clk); while (busy);
    take_transfer(mode, x, y, px);
  endtask

  task automatic fill_if_blank(int x, int y);
    if (!frame_written[y*MAX_WIDTH + x])
      send_item(MODE_STORE, POS_W'(x), POS_W'(y), random_pixel());
  endtask

  // Write any neighbor that was never stored, then send the sample itself.
  task automatic sample_at(logic [POS_W-1:0] x, logic [POS_W-1:0] y);
    int xl;
    int xr;
    int yu;
    int yd;
    if (map_neighbors(x, y, xl, xr, yu, yd)) begin
      fill_if_blank(xl, yu);
      fill_if_blank(xr, yu);
      fill_if_blank(xl, yd);
      fill_if_blank(xr, yd);
    end
    send_item(MODE_SAMPLE, x, y, random_pixel());
  endtask

  // Drop start, drain every pending pixel, then let queued stores retire.
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      awfc_pkg::REG_SRC_WIDTH:  warp_cfg.src_width  = data[SIZE_W-1:0];
      awfc_pkg::REG_SRC_HEIGHT: warp_cfg.src_height = data[SIZE_W-1:0];
      awfc_pkg::REG_COEF_XX:    warp_cfg.coef_xx    = data;
      awfc_pkg::REG_COEF_XY:    warp_cfg.coef_xy    = data;
      awfc_pkg::REG_COEF_YX:    warp_cfg.coef_yx    = data;
      awfc_pkg::REG_COEF_YY:    warp_cfg.coef_yy    = data;
      awfc_pkg::REG_OFFSET_X:   warp_cfg.offset_x   = data;
      awfc_pkg::REG_OFFSET_Y:   warp_cfg.offset_y   = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Reprogram the whole warp while the block is idle. Size writes carry
  // random junk above the size field, which the block must drop.
  task automatic set_warp(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h,
                          logic [COEF_W-1:0] xx, logic [COEF_W-1:0] xy,
                          logic [COEF_W-1:0] yx, logic [COEF_W-1:0] yy,
                          logic [COEF_W-1:0] ox, logic [COEF_W-1:0] oy);
    settle();
    write_reg(awfc_pkg::REG_SRC_WIDTH, {(CFG_W-SIZE_W)'($urandom), w});
    write_reg(awfc_pkg::REG_SRC_HEIGHT, {(CFG_W-SIZE_W)'($urandom), h});
    write_reg(awfc_pkg::REG_COEF_XX, xx);
    write_reg(awfc_pkg::REG_COEF_XY, xy);
    write_reg(awfc_pkg::REG_COEF_YX, yx);
    write_reg(awfc_pkg::REG_COEF_YY, yy);
    write_reg(awfc_pkg::REG_OFFSET_X, ox);
    write_reg(awfc_pkg::REG_OFFSET_Y, oy);
    warp_settings++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset settings: identity over the full frame. Hit two corners with extreme colors,
  // miss past the right and bottom edges, and send stores past the frame that must drop.
  task automatic test_directed_edges();
    send_item(MODE_STORE, 0, 0, 24'hFFFFFF);
    send_item(MODE_STORE, 1, 0, 24'h000000);
    send_item(MODE_STORE, 0, 1, 24'hFF00FF);
    send_item(MODE_STORE, 1, 1, 24'h00FF00);
    sample_at(0, 0);
    send_item(MODE_STORE, 254, 254, 24'h0102FE);
    send_item(MODE_STORE, 255, 254, 24'hFFFFFF);
    send_item(MODE_STORE, 254, 255, 24'h7F80FF);
    send_item(MODE_STORE, 255, 255, 24'hFFFFFF);
    sample_at(255, 255);
    sample_at(256, 10);
    sample_at(10, 256);
    sample_at(12'hFFF, 12'hFFF);
    send_item(MODE_STORE, 12'hFFF, 0, 24'h000000);
    send_item(MODE_STORE, 0, 12'hFFF, 24'h000000);
    send_item(MODE_STORE, 256, 256, 24'h000000);
    send_item(MODE_STORE, 12'hF00, 12'h0FF, 24'h000000);
    sample_at(0, 0);
    sample_at(1, 1);
  endtask

  // Size codes at and past both ends, probing the last column and row and
  // the first point beyond each.
  task automatic test_size_extremes();
    logic [SIZE_W-1:0] size_codes [6] = '{9'd0, 9'd1, 9'd2, 9'd256, 9'd257, 9'd511};
    int w_eff;
    int h_eff;
    for (int i = 0; i < 6; i++) begin
      set_warp(size_codes[i], size_codes[(i + 3) % 6], ONE_Q16, '0, '0, ONE_Q16, '0, '0);
      w_eff = eff_size(size_codes[i], MAX_WIDTH);
      h_eff = eff_size(size_codes[(i + 3) % 6], MAX_HEIGHT);
      sample_at(0, 0);
      sample_at(POS_W'(w_eff - 1), POS_W'(h_eff - 1));
      sample_at(POS_W'(w_eff), 0);
      sample_at(0, POS_W'(h_eff));
    end
  endtask

  task automatic test_coef_extremes();
    // Saturated matrix and offsets: the sums run far past 32 bits.
    set_warp(9'd256, 9'd256, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
             32'h8000_0000, 32'h7FFF_FFFF);
    sample_at(0, 0);
    sample_at(12'hFFF, 12'hFFF);
    sample_at(12'hFFF, 0);
    sample_at(0, 12'hFFF);
    // Zero matrix: every destination collapses onto one source point.
    set_warp(9'd16, 9'd16, '0, '0, '0, '0, 32'h0003_FFFF, 32'h0000_0000);
    repeat (4) sample_at(POS_W'($urandom), POS_W'($urandom));
    // Source x one LSB below zero must floor to -1 and miss.
    set_warp(9'd16, 9'd16, ONE_Q16, '0, '0, ONE_Q16, 32'hFFFF_FFFF, 32'h0000_FFFF);
    sample_at(0, 0);
    sample_at(5, 5);
    // Mirror in x, half scale in y.
    set_warp(9'd16, 9'd16, 32'hFFFF_0000, '0, '0, 32'h0000_8000, 32'h000F_8000, '0);
    sample_at(0, 0);
    sample_at(15, 31);
    sample_at(16, 0);
  endtask

  // Phases of random warps. Most keep the mapping near the frame so that samples
  // land inside; one in ten uses raw 32-bit coefficients. Each phase mixes samples,
  // overwrites inside the frame and stores past it that must drop.
  task automatic test_random_warps();
    int budget_end;
    int kind;
    int n;
    int w_eff;
    int h_eff;
    int span_x;
    int span_y;
    int pick;
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
    logic [COEF_W-1:0] xx;
    logic [COEF_W-1:0] xy;
    logic [COEF_W-1:0] yx;
    logic [COEF_W-1:0] yy;
    logic [COEF_W-1:0] ox;
    logic [COEF_W-1:0] oy;
    budget_end = useful_items + RANDOM_ITEMS;
    while (useful_items < budget_end) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        w  = SIZE_W'($urandom);
        h  = SIZE_W'($urandom);
        xx = $urandom;
        xy = $urandom;
        yx = $urandom;
        yy = $urandom;
        ox = $urandom;
        oy = $urandom;
      end else begin
        w  = random_size();
        h  = random_size();
        xx = random_scale();
        yy = random_scale();
        // Shear or rotation in about half the phases.
        xy = (kind < 5) ? int'($urandom_range(0, ONE_Q16)) - ONE_Q16 / 2 : 0;
        yx = (kind < 5) ? int'($urandom_range(0, ONE_Q16)) - ONE_Q16 / 2 : 0;
        // Shift mirrored axes back over the frame, then jitter a few pixels.
        ox = ($signed(xx) < 0 ? (eff_size(w, MAX_WIDTH) - 1) << FRAC_BITS : 0)
             + (int'($urandom_range(0, 16)) - 8) * ONE_Q16 + $urandom_range(0, ONE_Q16 - 1);
        oy = ($signed(yy) < 0 ? (eff_size(h, MAX_HEIGHT) - 1) << FRAC_BITS : 0)
             + (int'($urandom_range(0, 16)) - 8) * ONE_Q16 + $urandom_range(0, ONE_Q16 - 1);
      end
      set_warp(w, h, xx, xy, yx, yy, ox, oy);
      w_eff   = eff_size(w, MAX_WIDTH);
      h_eff   = eff_size(h, MAX_HEIGHT);
      span_x  = (4 * w_eff + 8 > 4095) ? 4095 : 4 * w_eff + 8;
      span_y  = (4 * h_eff + 8 > 4095) ? 4095 : 4 * h_eff + 8;
      no_idle = ($urandom_range(0, 3) == 0);
      n = $urandom_range(20, 60);
      repeat (n) begin
        pick = $urandom_range(0, 19);
        if (pick < 12) begin
          if ($urandom_range(0, 9) == 0) sample_at(POS_W'($urandom), POS_W'($urandom));
          else sample_at(POS_W'($urandom_range(0, span_x)), POS_W'($urandom_range(0, span_y)));
        end else if (pick < 18) begin
          send_item(MODE_STORE, POS_W'($urandom_range(0, w_eff + 1)),
                    POS_W'($urandom_range(0, h_eff + 1)), random_pixel());
        end else if (pick == 18) begin
          send_item(MODE_STORE, POS_W'($urandom_range(MAX_WIDTH, 4095)), POS_W'($urandom),
                    random_pixel());
        end else begin
          send_item(MODE_STORE, POS_W'($urandom), POS_W'($urandom_range(MAX_HEIGHT, 4095)),
                    random_pixel());
        end
      end
    end
    no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result check: every strobe must match the oldest pending pixel.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_pixels.size() == 0) begin
        $error("out_valid with no sample pending");
        mismatch_count++;
      end else begin
        head_pixel = pending_pixels.pop_front();
        if (out_red !== head_pixel.red) begin
          $error("red mismatch: expected %0d, got %0d", head_pixel.red, out_red);
          mismatch_count++;
        end
        if (out_green !== head_pixel.green) begin
          $error("green mismatch: expected %0d, got %0d", head_pixel.green, out_green);
          mismatch_count++;
        end
        if (out_blue !== head_pixel.blue) begin
          $error("blue mismatch: expected %0d, got %0d", head_pixel.blue, out_blue);
          mismatch_count++;
        end
        if (out_inside_res !== head_pixel.in_src) begin
          $error("inside_res mismatch: expected %0d, got %0d", head_pixel.in_src,
                 out_inside_res);
          mismatch_count++;
        end
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #(RUN_LIMIT_NS);
    $display("timeout: %0d pixels still pending", pending_pixels.size());
    $display("status: fail");
    $finish;
  end

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_mode   = MODE_STORE;
    in_pos_x  = '0;
    in_pos_y  = '0;
    in_red    = '0;
    in_green  = '0;
    in_blue   = '0;
    cfg_we    = 1'b0;
    cfg_index = awfc_pkg::REG_SRC_WIDTH;
    cfg_wdata = '0;
    no_idle   = 1'b0;
    // Register defaults after reset: identity over the full frame.
    warp_cfg            = '0;
    warp_cfg.src_width  = SIZE_W'(MAX_WIDTH);
    warp_cfg.src_height = SIZE_W'(MAX_HEIGHT);
    warp_cfg.coef_xx    = ONE_Q16;
    warp_cfg.coef_yy    = ONE_Q16;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_directed_edges();
    test_size_extremes();
    test_coef_extremes();
    test_random_warps();
    settle();

    $display("covered %0d transfers: %0d samples inside the source, %0d outside",
             transfers, samples_inside, samples_outside);
    $display("over %0d warp settings with %0d field mismatches", warp_settings,
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### affine_warp_four_corner_sampler_top.f
+incdir+design
design/awfc_pkg.sv
design/awfc_front.sv
design/awfc_fifo.sv
design/awfc_back.sv
design/affine_warp_four_corner_sampler_top.sv
test/affine_warp_four_corner_sampler_top_tb.sv
